// ===== hw/rtl/vpv_pkg.sv =====
package vpv_pkg;

  localparam int MAX_LINES    = 64;
  localparam int GRID_COLUMNS = 33;
  localparam int GRID_ROWS    = 23;
  localparam int COORD_BITS   = 12;

  localparam int GRID_CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam int CELL_W     = $clog2(GRID_CELLS);
  localparam int COL_W      = $clog2(GRID_COLUMNS);
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int LINE_IDX_W = $clog2(MAX_LINES);
  localparam int COUNT_W    = $clog2(MAX_LINES + 1);
  localparam int STORE_W    = 4 * COORD_BITS;

  // Intersection arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int DEN_W  = 2 * DIFF_W + 1;
  localparam int PROD_W = DEN_W + DIFF_W;
  localparam int NX_W   = PROD_W + 1;
  localparam int DIV_STEPS = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DIV_BIT_W = $clog2(DIV_STEPS);

  localparam int FILT_W = COORD_BITS + 16;
  localparam logic [FILT_W-1:0] TAN5_Q16  = FILT_W'(5734);
  localparam logic [FILT_W-1:0] TAN10_Q16 = FILT_W'(11556);

  localparam int VOTE_W = 11;
  localparam logic [VOTE_W-1:0] VOTE_MAX = '1;
  localparam int CORNER_W = 12;
  localparam logic [CORNER_W-1:0] CORNER_MAX = '1;

  localparam int CW_W      = 7;
  localparam int CH_W      = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 1'b1;
  localparam logic [CW_W-1:0] CELL_WIDTH_RESET  = 7'd19;
  localparam logic [CH_W-1:0] CELL_HEIGHT_RESET = 8'd15;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic                  has_line;
    logic                  last_line;
  } line_t;

  typedef struct packed {
    logic                detected;
    logic [5:0]          best_column;
    logic [4:0]          best_row;
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic [VOTE_W-1:0]   vote_count;
    logic [6:0]          kept_lines;
  } result_t;

endpackage

// ===== hw/rtl/vpv_ram.sv =====
module vpv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/vanishing_point_vote.sv =====
// Vanishing-point voting over the line segments of one frame.
// Input channel line (line_valid / line_stall): one segment per transfer.
// has_line = 0 makes the transfer an empty marker; last_line closes the frame.
// Zero-length and near horizontal/vertical segments are dropped, the rest stored.
// The store keeps up to MAX_LINES segments; line_stall is low only in idle.
// On the last_line transfer, if both cell sizes are nonzero and two or more
// segments are stored, every pair of them is intersected and votes into the
// cell grid when its point lies inside it; then the grid is scanned for the
// first cell with the most votes and cleared in the same sweep. A pair uses
// one shared multiplier over up to 14 steps, a 6-step restoring divide and
// a read-modify-write of the grid memory. When the scan is done, one result
// appears on result / result_valid.
// A stalled result holds; the block waits in its final step until taken.
// Configuration writes (cfg_write, cfg_index, cfg_data) set the cell size.
// After reset the grid memory is cleared cell by cell, with
// line_stall high.
module vanishing_point_vote
  import vpv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  output logic                 line_stall,
  input  line_t                line,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDA, S_RDB, S_LOADB, S_MATH, S_DIV,
    S_VRD, S_VWR, S_SCAN, S_TAIL, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    M_DEN_A, M_DEN_B, M_NUM_A, M_NUM_B, M_NUM_C, M_NX_A, M_NX_B,
    M_NX_C, M_NY_A, M_NY_B, M_WX, M_WY, M_LIM, M_CHECK
  } math_step_t;

  localparam logic signed [NX_W-1:0] COLS_S = NX_W'(GRID_COLUMNS);
  localparam logic signed [NX_W-1:0] ROWS_S = NX_W'(GRID_ROWS);

  state_t     state;
  math_step_t mstep;

  logic [CW_W-1:0]       cw;
  logic [CH_W-1:0]       ch;
  logic [COUNT_W-1:0]    count;
  logic [LINE_IDX_W-1:0] pi, pj;
  logic [STORE_W-1:0]    la, lb;
  logic [CELL_W-1:0]     k;
  logic [COL_W-1:0]      scol, svcol, bc;
  logic [ROW_W-1:0]      srow, svrow, br;
  logic                  sv;
  logic [VOTE_W-1:0]     best;

  logic signed [PROD_W-1:0] prod, t0;
  logic signed [DEN_W-1:0]  den, num;
  logic                     neg;
  logic signed [NX_W-1:0]   nx, ny, wx, wy, limx, limy;
  logic [NX_W-1:0]          remx, remy;
  logic [DIV_STEPS-1:0]     qx, qy;
  logic [DIV_BIT_W-1:0]     dbit;

  // Angle filter
  logic signed [DIFF_W-1:0] fdx, fdy;
  logic [COORD_BITS-1:0]    fax, fay;
  logic                     keep, store_we;
  logic [COUNT_W-1:0]       count_new;
  logic                     accept, pairs_ok;

  always_comb begin
    fdx = $signed({1'b0, line.end_x}) - $signed({1'b0, line.start_x});
    fdy = $signed({1'b0, line.start_y}) - $signed({1'b0, line.end_y});
    fax = fdx[DIFF_W-1] ? COORD_BITS'(-fdx) : COORD_BITS'(fdx);
    fay = fdy[DIFF_W-1] ? COORD_BITS'(-fdy) : COORD_BITS'(fdy);
    keep = !(fax == '0 && fay == '0)
        && !({fay, 16'b0} < TAN5_Q16 * FILT_W'(fax))
        && !({fax, 16'b0} < TAN10_Q16 * FILT_W'(fay));
  end

  assign line_stall = (state != S_IDLE);
  assign accept     = line_valid && !line_stall;
  assign store_we   = accept && line.has_line && keep && (count < COUNT_W'(MAX_LINES));
  assign count_new  = store_we ? count + 1'b1 : count;
  assign pairs_ok   = (cw != '0) && (ch != '0) && (count_new > COUNT_W'(1));

  // Segment fields of the pair
  logic [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic signed [DIFF_W-1:0] d1x, d1y, d2x, d2y, ox, oy;

  assign {y2, x2, y1, x1} = la;
  assign {y4, x4, y3, x3} = lb;

  always_comb begin
    d1x = $signed({1'b0, x2}) - $signed({1'b0, x1});
    d1y = $signed({1'b0, y2}) - $signed({1'b0, y1});
    d2x = $signed({1'b0, x4}) - $signed({1'b0, x3});
    d2y = $signed({1'b0, y4}) - $signed({1'b0, y3});
    ox  = $signed({1'b0, x3}) - $signed({1'b0, x1});
    oy  = $signed({1'b0, y3}) - $signed({1'b0, y1});
  end

  // Shared multiplier operand select
  logic signed [DEN_W-1:0]  ma;
  logic signed [DIFF_W-1:0] mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (mstep)
      M_DEN_A: begin ma = DEN_W'(d1x); mb = d2y; end
      M_DEN_B: begin ma = DEN_W'(d1y); mb = d2x; end
      M_NUM_A: begin ma = DEN_W'(ox);  mb = d2y; end
      M_NUM_B: begin ma = DEN_W'(oy);  mb = d2x; end
      M_NX_A:  begin ma = den; mb = $signed({1'b0, x1}); end
      M_NX_B:  begin ma = num; mb = d1x; end
      M_NX_C:  begin ma = den; mb = $signed({1'b0, y1}); end
      M_NY_A:  begin ma = num; mb = d1y; end
      M_NY_B:  begin ma = den; mb = $signed({{(DIFF_W-CW_W){1'b0}}, cw}); end
      M_WX:    begin ma = den; mb = $signed({{(DIFF_W-CH_W){1'b0}}, ch}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [PROD_W-1:0] pdiff;
  logic signed [NX_W-1:0]   psum;
  logic                     reject;

  assign pdiff  = t0 - prod;
  assign psum   = NX_W'(t0) + NX_W'(prod);
  assign reject = (nx <= 0) || (ny <= 0) || (nx >= limx) || (ny >= limy);

  // Divide step
  logic [NX_W-1:0] trialx, trialy;
  assign trialx = NX_W'($unsigned(wx)) << dbit;
  assign trialy = NX_W'($unsigned(wy)) << dbit;

  // Grid memory
  logic [CELL_W-1:0] vaddr, g_waddr, g_raddr;
  logic [VOTE_W-1:0] g_wdata, g_rdata, g_inc;
  logic              g_we;

  assign vaddr   = CELL_W'(qx[COL_W-1:0] * GRID_ROWS) + CELL_W'(qy[ROW_W-1:0]);
  assign g_inc   = (g_rdata == VOTE_MAX) ? g_rdata : g_rdata + 1'b1;
  assign g_we    = (state == S_CLEAR) || (state == S_SCAN) || (state == S_VWR);
  assign g_waddr = (state == S_VWR) ? vaddr : k;
  assign g_wdata = (state == S_VWR) ? g_inc : '0;
  assign g_raddr = (state == S_VRD) ? vaddr : k;

  vpv_ram #(.WIDTH(VOTE_W), .DEPTH(GRID_CELLS)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  // Line store
  logic [STORE_W-1:0]    ls_rdata;
  logic [LINE_IDX_W-1:0] ls_raddr;

  assign ls_raddr = (state == S_RDA) ? pi : pj;

  vpv_ram #(.WIDTH(STORE_W), .DEPTH(MAX_LINES)) u_lines (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[LINE_IDX_W-1:0]),
    .wdata ({line.end_y, line.end_x, line.start_y, line.start_x}),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  // Pair sequencing
  logic pair_end, j_more, i_more, scan_go;

  assign j_more = (COUNT_W'(pj) + 1'b1) < count;
  assign i_more = (COUNT_W'(pi) + COUNT_W'(2)) < count;
  assign pair_end = (state == S_VWR)
      || (state == S_MATH && mstep == M_NUM_B && den == '0)
      || (state == S_MATH && mstep == M_CHECK && reject);
  assign scan_go = (pair_end && !j_more && !i_more)
      || (accept && line.last_line && !pairs_ok);

  // Corner
  logic [COL_W+CW_W-1:0] cx;
  logic [ROW_W+CH_W-1:0] cy;
  assign cx = (COL_W+CW_W)'(bc) * (COL_W+CW_W)'(cw);
  assign cy = (ROW_W+CH_W)'(br) * (ROW_W+CH_W)'(ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      k            <= '0;
      count        <= '0;
      cw           <= CELL_WIDTH_RESET;
      ch           <= CELL_HEIGHT_RESET;
      result_valid <= 1'b0;
      sv           <= 1'b0;
      mstep        <= M_DEN_A;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_CELL_WIDTH:  cw <= cfg_data[CW_W-1:0];
          REG_CELL_HEIGHT: ch <= cfg_data[CH_W-1:0];
        endcase
      end

      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      prod <= ma * mb;

      unique case (state)
        S_CLEAR: begin
          k <= k + 1'b1;
          if (k == CELL_W'(GRID_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          count <= count_new;
          if (accept && line.last_line && pairs_ok) begin
            pi    <= '0;
            pj    <= LINE_IDX_W'(1);
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          la    <= ls_rdata;
          state <= S_LOADB;
        end
        S_LOADB: begin
          lb    <= ls_rdata;
          mstep <= M_DEN_A;
          state <= S_MATH;
        end
        S_MATH: begin
          mstep <= math_step_t'(mstep + 4'd1);
          case (mstep)
            M_DEN_B: t0 <= prod;
            M_NUM_A: den <= DEN_W'(pdiff);
            M_NUM_B: begin
              t0  <= prod;
              neg <= den[DEN_W-1];
              den <= den[DEN_W-1] ? -den : den;
            end
            M_NUM_C: num <= neg ? DEN_W'(-pdiff) : DEN_W'(pdiff);
            M_NX_B:  t0 <= prod;
            M_NX_C:  nx <= psum;
            M_NY_A:  t0 <= prod;
            M_NY_B:  ny <= psum;
            M_WX:    wx <= NX_W'(prod);
            M_WY: begin
              wy   <= NX_W'(prod);
              limx <= wx * COLS_S;
            end
            M_LIM:   limy <= wy * ROWS_S;
            M_CHECK: begin
              remx  <= $unsigned(nx);
              remy  <= $unsigned(ny);
              qx    <= '0;
              qy    <= '0;
              dbit  <= DIV_BIT_W'(DIV_STEPS - 1);
              state <= S_DIV;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (remx >= trialx) begin
            remx     <= remx - trialx;
            qx[dbit] <= 1'b1;
          end
          if (remy >= trialy) begin
            remy     <= remy - trialy;
            qy[dbit] <= 1'b1;
          end
          if (dbit == '0) begin
            state <= S_VRD;
          end else begin
            dbit <= dbit - 1'b1;
          end
        end
        S_VRD: state <= S_VWR;
        S_VWR: ;
        S_SCAN: begin
          sv    <= 1'b1;
          svcol <= scol;
          svrow <= srow;
          k     <= k + 1'b1;
          if (srow == ROW_W'(GRID_ROWS - 1)) begin
            srow <= '0;
            scol <= scol + 1'b1;
          end else begin
            srow <= srow + 1'b1;
          end
          if (k == CELL_W'(GRID_CELLS - 1)) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          sv    <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          // hold the finished result until the output register is free
          if (!result_valid || !result_stall) begin
            result.detected    <= (best != '0);
            result.best_column <= 6'(bc);
            result.best_row    <= 5'(br);
            result.corner_x    <= (cx > (COL_W+CW_W)'(CORNER_MAX)) ? CORNER_MAX
                                                                   : CORNER_W'(cx);
            result.corner_y    <= (cy > (ROW_W+CH_W)'(CORNER_MAX)) ? CORNER_MAX
                                                                   : CORNER_W'(cy);
            result.vote_count  <= best;
            result.kept_lines  <= 7'(count);
            result_valid       <= 1'b1;
            count              <= '0;
            state              <= S_IDLE;
          end
        end
      endcase

      if ((state == S_SCAN || state == S_TAIL) && sv && g_rdata > best) begin
        best <= g_rdata;
        bc   <= svcol;
        br   <= svrow;
      end

      if (pair_end) begin
        if (j_more) begin
          pj    <= pj + 1'b1;
          state <= S_RDA;
        end else if (i_more) begin
          pi    <= pi + 1'b1;
          pj    <= pi + LINE_IDX_W'(2);
          state <= S_RDA;
        end
      end

      if (scan_go) begin
        k     <= '0;
        scol  <= '0;
        srow  <= '0;
        sv    <= 1'b0;
        best  <= '0;
        bc    <= '0;
        br    <= '0;
        state <= S_SCAN;
      end
    end
  end

endmodule

// ===== hw/rtl/vpv_check.sv =====
module vpv_check
  import vpv_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    line_valid,
  input logic    line_stall,
  input line_t   line,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a stalled result holds its place and value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_no_vote_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.detected |->
      result.vote_count == '0 && result.best_column == '0 && result.best_row == '0
      && result.corner_x == '0 && result.corner_y == '0)
    else $error("undetected result carries a cell");

  a_detect_votes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.detected |->
      result.vote_count != '0 && result.best_column < 6'(GRID_COLUMNS)
      && result.best_row < 5'(GRID_ROWS))
    else $error("detected result out of range");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.kept_lines <= 7'(MAX_LINES))
    else $error("kept line count beyond store depth");

  // the frame-closing transfer starts the vote or the scan, so the input stalls next
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_stall && line.last_line |=> line_stall)
    else $error("input not stalled after the last line of a frame");

endmodule

bind vanishing_point_vote vpv_check u_vpv_check (.*);

// ===== tb/tb_vanishing_point_vote.sv =====
`timescale 1ns / 1ps

module tb_vanishing_point_vote;
  import vpv_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 line_valid = 1'b0;
  logic                 line_stall;
  line_t                line = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CELL_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  vanishing_point_vote uut (
    .clk(clk), .rst(rst),
    .line_valid(line_valid), .line_stall(line_stall), .line(line),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model copy of the block state
  logic [CW_W-1:0] model_width = CELL_WIDTH_RESET;
  logic [CH_W-1:0] model_height = CELL_HEIGHT_RESET;
  line_t           kept_store[MAX_LINES];
  int              kept_count = 0;
  int              cell_votes[GRID_CELLS];

  result_t vp_expected[$];
  int      errors = 0;
  int      items_sent = 0;
  int      frames_done = 0;
  int      results_seen = 0;
  int      detections = 0;
  bit      quiet = 1'b0;
  bit      use_typed = 1'b0;
  result_t typed_result = '0;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic bit segment_kept(input line_t s);
    longint dx, dy, ax, ay;
    dx = longint'(s.end_x) - longint'(s.start_x);
    dy = longint'(s.start_y) - longint'(s.end_y);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax == 0 && ay == 0) return 1'b0;
    if (ay * 65536 < 5734 * ax) return 1'b0;
    if (ax * 65536 < 11556 * ay) return 1'b0;
    return 1'b1;
  endfunction

  task automatic cast_vote(input line_t a, input line_t b);
    longint x1, y1, d1x, d1y, x3, y3, d2x, d2y, den, num, nx, ny, wx, wy, col, row;
    x1 = a.start_x;
    y1 = a.start_y;
    d1x = longint'(a.end_x) - x1;
    d1y = longint'(a.end_y) - y1;
    x3 = b.start_x;
    y3 = b.start_y;
    d2x = longint'(b.end_x) - x3;
    d2y = longint'(b.end_y) - y3;
    den = d1x * d2y - d1y * d2x;
    if (den == 0) return;
    num = (x3 - x1) * d2y - (y3 - y1) * d2x;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    nx = x1 * den + d1x * num;
    ny = y1 * den + d1y * num;
    wx = longint'(model_width) * den;
    wy = longint'(model_height) * den;
    if (nx <= 0 || ny <= 0) return;
    if (nx >= wx * GRID_COLUMNS || ny >= wy * GRID_ROWS) return;
    col = nx / wx;
    row = ny / wy;
    if (col >= GRID_COLUMNS || row >= GRID_ROWS) return;
    if (cell_votes[col * GRID_ROWS + row] < 2047) cell_votes[col * GRID_ROWS + row]++;
  endtask

  task automatic close_frame(output result_t r);
    int best, bc, br;
    longint cx, cy;
    best = 0;
    bc = 0;
    br = 0;
    foreach (cell_votes[k]) cell_votes[k] = 0;
    if (model_width != 0 && model_height != 0 && kept_count > 1)
      for (int i = 0; i + 1 < kept_count; i++)
        for (int j = i + 1; j < kept_count; j++)
          cast_vote(kept_store[i], kept_store[j]);
    for (int c = 0; c < GRID_COLUMNS; c++)
      for (int w = 0; w < GRID_ROWS; w++)
        if (cell_votes[c * GRID_ROWS + w] > best) begin
          best = cell_votes[c * GRID_ROWS + w];
          bc = c;
          br = w;
        end
    cx = longint'(bc) * model_width;
    cy = longint'(br) * model_height;
    if (cx > 4095) cx = 4095;
    if (cy > 4095) cy = 4095;
    r.detected = best > 0;
    r.best_column = bc[5:0];
    r.best_row = br[4:0];
    r.corner_x = cx[11:0];
    r.corner_y = cy[11:0];
    r.vote_count = best[10:0];
    r.kept_lines = kept_count[6:0];
    kept_count = 0;
  endtask

  // sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (cfg_write) begin
        if (cfg_index == REG_CELL_WIDTH) model_width = cfg_data[CW_W-1:0];
        else model_height = cfg_data[CH_W-1:0];
      end
      if (line_valid && !line_stall) begin
        if (line.has_line && segment_kept(line) && kept_count < MAX_LINES) begin
          kept_store[kept_count] = line;
          kept_count++;
        end
        if (line.last_line) begin
          close_frame(want);
          vp_expected.insert(vp_expected.size(), use_typed ? typed_result : want);
          frames_done++;
        end
      end
      if (result_valid && !result_stall) begin
        got = result;
        results_seen++;
        if (got.detected) detections++;
        if (vp_expected.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = vp_expected.pop_front();
          if (got.detected !== want.detected)
            report($sformatf("detected %0d, want %0d", got.detected, want.detected));
          if (got.best_column !== want.best_column)
            report($sformatf("best_column %0d, want %0d", got.best_column, want.best_column));
          if (got.best_row !== want.best_row)
            report($sformatf("best_row %0d, want %0d", got.best_row, want.best_row));
          if (got.corner_x !== want.corner_x)
            report($sformatf("corner_x %0d, want %0d", got.corner_x, want.corner_x));
          if (got.corner_y !== want.corner_y)
            report($sformatf("corner_y %0d, want %0d", got.corner_y, want.corner_y));
          if (got.vote_count !== want.vote_count)
            report($sformatf("vote_count %0d, want %0d", got.vote_count, want.vote_count));
          if (got.kept_lines !== want.kept_lines)
            report($sformatf("kept_lines %0d, want %0d", got.kept_lines, want.kept_lines));
        end
      end
    end
  end

  // result side: alternate stall bursts and free runs
  int hold_left = 0;
  always @(negedge clk) begin
    if (quiet) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (result_stall) begin
      result_stall <= 1'b0;
      hold_left = $urandom_range(1, 60);
    end else begin
      result_stall <= 1'b1;
      hold_left = $urandom_range(1, 19);
    end
  end

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_line(input line_t it);
    line <= it;
    line_valid <= 1'b1;
    do @(posedge clk); while (line_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic sender_gap(input bit idle_on);
    if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
      line_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic drain;
    line_valid <= 1'b0;
    while (vp_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic line_t seg(input int sx, sy, ex, ey, input bit has, last);
    line_t s;
    s.start_x = sx[11:0];
    s.start_y = sy[11:0];
    s.end_x = ex[11:0];
    s.end_y = ey[11:0];
    s.has_line = has;
    s.last_line = last;
    return s;
  endfunction

  function automatic result_t res(input int det, col, row, cx, cy, votes, kept);
    result_t r;
    r.detected = det[0];
    r.best_column = col[5:0];
    r.best_row = row[4:0];
    r.corner_x = cx[11:0];
    r.corner_y = cy[11:0];
    r.vote_count = votes[10:0];
    r.kept_lines = kept[6:0];
    return r;
  endfunction

  function automatic int span(input int cells, input int size);
    int v;
    v = cells * size;
    if (size == 0 || v > 4095) v = 4095;
    if (v < 3) v = 3;
    return v;
  endfunction

  // one frame: mostly segments through a common point inside the grid
  task automatic run_frame(input int n_items, input bit idle_on);
    int vx, vy, px, py, roll;
    line_t s;
    vx = $urandom_range(1, span(GRID_COLUMNS, model_width) - 1);
    vy = $urandom_range(1, span(GRID_ROWS, model_height) - 1);
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      px = $urandom_range(0, 4095);
      py = $urandom_range(0, 4095);
      if (roll < 75) begin
        if (roll[0]) s = seg(px, py, vx, vy, 1'b1, 1'b0);
        else s = seg(vx, vy, px, py, 1'b1, 1'b0);
      end else if (roll < 90) begin
        s = seg(px, py, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1, 1'b0);
      end else begin
        s = seg(px, py, $urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 1'b0);
      end
      s.last_line = (k == n_items - 1);
      send_line(s);
      sender_gap(idle_on);
    end
  endtask

  typedef struct {
    line_t   item;
    bit      typed;
    result_t want;
  } stim_row_t;

  stim_row_t directed[$];
  int        widths[8]  = '{19, 1, 124, 255, 0, 60, 7, 40};
  int        heights[8] = '{15, 1, 178, 255, 15, 0, 9, 20};

  task automatic add_row(input line_t item, input bit typed, input result_t want);
    stim_row_t r;
    r.item = item;
    r.typed = typed;
    r.want = want;
    directed.insert(directed.size(), r);
  endtask

  initial begin
    int big_frames, n, phase;
    big_frames = 0;
    phase = 0;
    add_row(seg(0, 0, 0, 0, 0, 1), 1, res(0, 0, 0, 0, 0, 0, 0));
    add_row(seg(0, 100, 4095, 100, 1, 0), 0, '0);
    add_row(seg(100, 0, 100, 4095, 1, 0), 0, '0);
    add_row(seg(5, 5, 5, 5, 1, 0), 0, '0);
    add_row(seg(4095, 4095, 4095, 4095, 0, 0), 0, '0);
    add_row(seg(4095, 4095, 4095, 4095, 0, 1), 1, res(0, 0, 0, 0, 0, 0, 0));
    add_row(seg(0, 0, 200, 200, 1, 0), 0, '0);
    add_row(seg(0, 400, 400, 0, 1, 1), 1, res(1, 10, 13, 190, 195, 1, 2));
    add_row(seg(4095, 4095, 0, 0, 1, 0), 0, '0);
    add_row(seg(0, 4095, 4095, 0, 1, 1), 1, res(0, 0, 0, 0, 0, 0, 2));
    // just inside and just outside both angle limits
    add_row(seg(0, 500, 1000, 412, 1, 0), 0, '0);
    add_row(seg(0, 500, 1000, 413, 1, 0), 0, '0);
    add_row(seg(300, 0, 477, 1000, 1, 0), 0, '0);
    add_row(seg(300, 0, 476, 1000, 1, 0), 0, '0);
    add_row(seg(0, 0, 0, 0, 0, 1), 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[r]) begin
      use_typed = directed[r].typed;
      typed_result = directed[r].want;
      send_line(directed[r].item);
    end
    use_typed = 1'b0;

    while (items_sent < 2000) begin
      if (frames_done % 30 == 0) begin
        drain();
        if (phase < 8) begin
          write_reg(REG_CELL_WIDTH, widths[phase][CFG_W-1:0]);
          write_reg(REG_CELL_HEIGHT, heights[phase][CFG_W-1:0]);
        end else begin
          write_reg(REG_CELL_WIDTH, CFG_W'($urandom_range(1, 124)));
          write_reg(REG_CELL_HEIGHT, CFG_W'($urandom_range(1, 178)));
        end
        phase++;
      end
      if (frames_done == 45) drain();
      quiet = items_sent > 1800;
      n = $urandom_range(1, 12);
      // overfill the line store, at most twice
      if (big_frames < 2 && $urandom_range(0, 59) == 0) begin
        n = $urandom_range(66, 72);
        big_frames++;
      end
      run_frame(n, $urandom_range(0, 2) != 0);
    end

    drain();
    repeat (50) @(negedge clk);
    $display("run covered %0d line transfers in %0d frames over %0d cell size settings",
             items_sent, frames_done, phase);
    $display("%0d results checked, %0d with a detected point", results_seen, detections);
    if (errors == 0 && vp_expected.size() == 0) begin
      $display("tb_vanishing_point_vote: clean");
    end else begin
      $display("tb_vanishing_point_vote: errors");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", vp_expected.size());
    $display("tb_vanishing_point_vote: errors");
    $finish;
  end

endmodule
